// ===== design/pulse_energy_meter_top_macros.svh =====
// Assertion helpers for the checker file of the pulse energy meter, pem_checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PULSE_ENERGY_METER_TOP_MACROS_SVH
`define PULSE_ENERGY_METER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse energy meter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse energy meter: next-cycle check failed");

`endif

// ===== design/pem_pkg.sv =====
package pem_pkg;

  // Command codes carried on tuser of the input stream and echoed on the output.
  localparam logic [1:0] CMD_PULSE  = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;

  // Rate mode codes (pulses per kWh).
  localparam logic [1:0] MODE_100   = 2'd0;
  localparam logic [1:0] MODE_10000 = 2'd2;

  // Configuration register indexes.
  localparam logic REG_RATE_MODE    = 1'b0;
  localparam logic REG_MIN_INTERVAL = 1'b1;

  // Mode constants: the numerators of the power divisions.
  localparam logic [31:0] K_100   = 32'd36000000;
  localparam logic [31:0] K_1000  = 32'd3600000;
  localparam logic [31:0] K_10000 = 32'd360000;

  localparam logic [31:0] ADD_MODE_100 = 32'd10;
  localparam logic [3:0]  TENTH_WRAP   = 4'd10;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM,
    ST_DIV_MEAN,
    ST_DIV_AVG,
    ST_DIV_INST,
    ST_DONE
  } pem_state_e;

endpackage

// ===== design/pulse_energy_meter_top.sv =====
// Pulse energy meter for a single S0 channel.
// Input words arrive on the s_axis group: tuser carries the command (pulse
// edge, report request or set energy) and tdata the pin level, the tick time
// and the energy value. Every accepted word produces exactly one result word
// on the m_axis group: tuser echoes the command, tdata carries the pulse and
// save flags, the two power figures and the energy count after the word.
// The block works on one word at a time. A pulse, set or unused command
// passes from ST_EXEC through ST_DONE into the output register, and the next
// word can be taken once the block is back in ST_IDLE. A report sweeps the
// interval ring through its memory port, one entry a cycle, forms the mean
// with a constant reciprocal multiplication and then runs two 32-step
// divisions on a shared restoring divider (average power, instant power).
// The input is ready again as soon as the result has moved into the output
// register, so a new word is taken while the previous result still waits.
// If the receiver stalls with a result already held, the next finished result
// waits inside the block and the input stays closed until it can move on.
// Reset clears the counters, the configuration to its defaults and the ring
// valid bits at once: no clearing pass is needed, unwritten entries read zero.
// Configuration writes are to be issued only while the block is idle.
module pulse_energy_meter_top
  import pem_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata, lowest bit up: pin_level[0], tick_time[32:1], energy_value[64:33],
  // zero padding[71:65].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command[1:0].
  input  logic [1:0]             s_axis_tuser,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata, lowest bit up: pulse_accepted[0], save_request[1],
  // instant_power[17:2], average_power[33:18], energy_total[65:34],
  // zero padding[71:66].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: result_kind[1:0].
  output logic [1:0]             m_axis_tuser
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RING_DEPTH);
  // The mean is the sum times the rounded-up reciprocal of the depth, shifted
  // down. With this shift it is exact for every sum that fits SUM_W bits.
  localparam int               MEAN_SH  = SUM_W + IDX_W;
  localparam logic [SUM_W:0]   MEAN_MUL = (SUM_W + 1)'(((64'd1 << MEAN_SH) +
                                          64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  function automatic logic [15:0] sat16(input logic [31:0] q);
    return (|q[31:16]) ? 16'hFFFF : q[15:0];
  endfunction

  // State machine.
  pem_state_e state_q, state_d;

  // Configuration.
  logic [1:0]  rate_mode_q;
  logic [15:0] min_int_q;

  // Captured input word.
  logic [1:0]  cmd_q;
  logic        pin_q;
  logic [31:0] tick_q;
  logic [31:0] value_q;

  // Scalar meter state.
  logic [31:0]      last_q;
  logic [IDX_W-1:0] pos_q;
  logic [31:0]      energy_q;
  logic [3:0]       tenth_q;

  // Interval ring: memory plus one valid bit per entry.
  logic [15:0]           ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;
  logic [15:0]           rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;

  // Report sweep.
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic [15:0]      newest_q;

  // Shared restoring divider.
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvsr_q;
  logic [4:0]  dcnt_q;

  // Pending result.
  logic [1:0]  res_kind_q;
  logic        res_acc_q;
  logic        res_save_q;
  logic [15:0] res_inst_q;
  logic [15:0] res_avg_q;

  // Output register.
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic [1:0]             out_tuser_q;

  // Control decoded from the state.
  logic        take_item;
  logic        do_exec;
  logic        do_sweep;
  logic        div_run;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        out_load;

  // Pulse datapath.
  logic [31:0]      gap;
  logic             pulse_ok;
  logic [IDX_W-1:0] pos_next;
  logic [3:0]       tenth_inc;
  logic [3:0]       tenth_next;
  logic             add_en;
  logic [31:0]      add_amt;
  logic [31:0]      energy_sum;
  logic [31:0]      k_const;

  // Sweep and divider datapath.
  logic [15:0]      rd_word;
  logic [SUM_W-1:0] sum_nx;
  logic             sweep_last;
  logic [2*SUM_W:0] mean_prod;
  logic [15:0]      mean_w;
  logic [32:0]      rem_sh;
  logic             div_ge;
  logic [32:0]      rem_sub;
  logic [31:0]      rem_nx;
  logic [31:0]      quo_nx;
  logic             div_last;

  assign gap      = tick_q - last_q;
  assign pulse_ok = (cmd_q == CMD_PULSE) && !pin_q && (gap >= {16'h0000, min_int_q});
  assign pos_next = (pos_q == IDX_LAST) ? '0 : pos_q + 1'b1;
  assign tenth_inc = tenth_q + 4'd1;

  always_comb begin
    add_en     = 1'b1;
    add_amt    = 32'd1;
    tenth_next = tenth_q;
    case (rate_mode_q)
      MODE_100: begin
        add_amt = ADD_MODE_100;
      end
      MODE_10000: begin
        // A tenth counter divides the pulses by ten before the count moves.
        if (tenth_inc >= TENTH_WRAP) begin
          tenth_next = 4'd0;
        end else begin
          tenth_next = tenth_inc;
          add_en     = 1'b0;
        end
      end
      default: begin
        add_amt = 32'd1;
      end
    endcase
  end

  assign energy_sum = energy_q + add_amt;

  always_comb begin
    case (rate_mode_q)
      MODE_100:   k_const = K_100;
      MODE_10000: k_const = K_10000;
      default:    k_const = K_1000;
    endcase
  end

  // Entries never written since reset read as zero.
  assign rd_word    = rd_vld_q ? rd_data_q : 16'h0000;
  assign sum_nx     = (cnt_q != '0) ? sum_q + SUM_W'(rd_word) : sum_q;
  assign sweep_last = (cnt_q == CNT_LAST);

  assign mean_prod = {{(SUM_W + 1){1'b0}}, sum_q} * {{SUM_W{1'b0}}, MEAN_MUL};
  assign mean_w    = mean_prod[MEAN_SH +: 16];

  // One restoring step. A zero divisor yields an all-ones quotient, which
  // saturates to the full-scale power just as required.
  assign rem_sh   = {rem_q, quo_q[31]};
  assign div_ge   = (rem_sh >= {1'b0, dvsr_q});
  assign rem_sub  = rem_sh - {1'b0, dvsr_q};
  assign rem_nx   = div_ge ? rem_sub[31:0] : rem_sh[31:0];
  assign quo_nx   = {quo_q[30:0], div_ge};
  assign div_last = (dcnt_q == 5'd31);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = (cmd_q == CMD_REPORT) ? ST_SUM : ST_DONE;
      end
      ST_SUM: begin
        if (sweep_last) state_d = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        state_d = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_last) state_d = ST_DIV_INST;
      end
      ST_DIV_INST: begin
        if (div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    take_item    = 1'b0;
    do_exec      = 1'b0;
    do_sweep     = 1'b0;
    div_run      = 1'b0;
    div_start    = 1'b0;
    div_dividend = k_const;
    div_divisor  = quo_nx;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        take_item = s_axis_tvalid;
      end
      ST_EXEC: begin
        do_exec = 1'b1;
      end
      ST_SUM: begin
        do_sweep = 1'b1;
      end
      ST_DIV_MEAN: begin
        // The full sum is in sum_q; the mean becomes the first divisor.
        div_start    = 1'b1;
        div_dividend = k_const;
        div_divisor  = {16'h0000, mean_w};
      end
      ST_DIV_AVG: begin
        div_run = 1'b1;
        if (div_last) begin
          div_start    = 1'b1;
          div_dividend = k_const;
          div_divisor  = {16'h0000, newest_q};
        end
      end
      ST_DIV_INST: begin
        div_run = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        take_item = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_mode_q <= 2'd1;
      min_int_q   <= 16'd16;
      last_q      <= '0;
      pos_q       <= '0;
      energy_q    <= '0;
      tenth_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RATE_MODE:    rate_mode_q <= cfg_data_i[1:0];
          REG_MIN_INTERVAL: min_int_q   <= cfg_data_i;
          default:          min_int_q   <= min_int_q;
        endcase
      end
      if (do_exec) begin
        if (pulse_ok) begin
          last_q            <= tick_q;
          pos_q             <= pos_next;
          valid_q[pos_next] <= 1'b1;
          tenth_q           <= tenth_next;
          if (add_en) energy_q <= energy_sum;
        end else if (cmd_q == CMD_SET) begin
          energy_q <= value_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_exec && pulse_ok) begin
      ring_mem[pos_next] <= gap[15:0];
    end
    rd_data_q <= ring_mem[cnt_q[IDX_W-1:0]];
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (take_item) begin
      cmd_q   <= s_axis_tuser;
      pin_q   <= s_axis_tdata[0];
      tick_q  <= s_axis_tdata[32:1];
      value_q <= s_axis_tdata[64:33];
    end

    rd_vld_q <= valid_q[cnt_q[IDX_W-1:0]];
    rd_idx_q <= cnt_q[IDX_W-1:0];

    if (do_exec) begin
      res_kind_q <= cmd_q;
      res_acc_q  <= pulse_ok;
      res_save_q <= pulse_ok && add_en && (energy_sum[9:0] == 10'd0);
      res_inst_q <= '0;
      res_avg_q  <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
    end

    if (do_sweep) begin
      cnt_q <= cnt_q + 1'b1;
      sum_q <= sum_nx;
      if ((cnt_q != '0) && (rd_idx_q == pos_q)) newest_q <= rd_word;
    end

    if (div_start) begin
      rem_q  <= '0;
      quo_q  <= div_dividend;
      dvsr_q <= div_divisor;
      dcnt_q <= '0;
    end else if (div_run) begin
      rem_q  <= rem_nx;
      quo_q  <= quo_nx;
      dcnt_q <= dcnt_q + 5'd1;
    end

    if (div_run && div_last) begin
      if (state_q == ST_DIV_AVG)  res_avg_q  <= sat16(quo_nx);
      if (state_q == ST_DIV_INST) res_inst_q <= sat16(quo_nx);
    end

    if (out_load) begin
      out_tuser_q <= res_kind_q;
      out_tdata_q <= {6'b000000, energy_q, res_avg_q, res_inst_q, res_save_q, res_acc_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule

// ===== design/pem_checker.sv =====
`include "pulse_energy_meter_top_macros.svh"

module pem_checker
  import pem_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser
);

  // A stalled result word holds its contents.
  `PEM_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Pulse flags are raised only on results of pulse words.
  `PEM_ASSERT_NOW(a_flags_pulse_only, m_axis_tvalid && (m_axis_tuser != CMD_PULSE), m_axis_tdata[1:0] == 2'b00)

  // Power figures appear only on results of report words.
  `PEM_ASSERT_NOW(a_power_report_only, m_axis_tvalid && (m_axis_tuser != CMD_REPORT), m_axis_tdata[33:2] == 32'd0)

  // A save request comes with an accepted pulse and a count on a 1024 boundary.
  `PEM_ASSERT_NOW(a_save_boundary, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0] && (m_axis_tdata[43:34] == 10'd0))

endmodule

bind pulse_energy_meter_top pem_checker u_pem_checker (.*);
